/* rtl/rle8d_pkg.sv */
`timescale 1ns / 1ps

package rle8d_pkg;

   localparam int COORD_BITS = 12;
   localparam int X_BITS     = COORD_BITS + 1;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [COORD_BITS-1:0] WIDTH_RESET  = 12'd320;
   localparam logic [COORD_BITS-1:0] HEIGHT_RESET = 12'd240;
   localparam logic [COORD_BITS-1:0] MIN_WIDTH    = 12'd8;

   // escape codes following a zero first byte
   localparam logic [7:0] ESC_EOL   = 8'h00;
   localparam logic [7:0] ESC_EOI   = 8'h01;
   localparam logic [7:0] ESC_DELTA = 8'h02;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [7:0]            run_length;
      logic [7:0]            pixel_value;
      logic                  last_of_run;
      logic                  frame_done;
   } rsp_item_type;

   // request after classification in the front end
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
      logic       is_eol;
      logic       is_eoi;
      logic       is_delta;
   } req_class_type;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SECOND,
      PH_DX,
      PH_DY,
      PH_LIT,
      PH_PAD
   } phase_type;

   typedef enum logic [2:0] {
      ST_FETCH,
      ST_EXEC,
      ST_WRAP,
      ST_RUN,
      ST_EOL,
      ST_END
   } ctl_state_type;

endpackage

/* rtl/rle8d_fifo.sv */
`timescale 1ns / 1ps

module rle8d_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

/* rtl/rle8d_front.sv */
`timescale 1ns / 1ps

module rle8d_front #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  rle8d_pkg::req_item_type  req_data,
   input  logic                     pop,
   output logic                     valid,
   output rle8d_pkg::req_class_type item
);

   localparam int CLW = $bits(rle8d_pkg::req_class_type);

   rle8d_pkg::req_class_type cls;
   logic [CLW-1:0]           q_dout;
   logic                     q_empty;

   always_comb begin
      cls.data_byte     = req_data.data_byte;
      cls.end_of_buffer = req_data.end_of_buffer;
      cls.is_eol        = (req_data.data_byte == rle8d_pkg::ESC_EOL);
      cls.is_eoi        = (req_data.data_byte == rle8d_pkg::ESC_EOI);
      cls.is_delta      = (req_data.data_byte == rle8d_pkg::ESC_DELTA);
   end

   rle8d_fifo #(
      .WIDTH(CLW),
      .DEPTH(DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push (req_push),
      .din  (cls),
      .full (req_full),
      .pop  (pop),
      .dout (q_dout),
      .empty(q_empty)
   );

   assign valid = !q_empty;
   assign item  = rle8d_pkg::req_class_type'(q_dout);

endmodule

/* rtl/rle8d_back.sv */
`timescale 1ns / 1ps

module rle8d_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [11:0]              frame_width,
   input  logic [11:0]              frame_height,
   input  logic                     in_valid,
   input  rle8d_pkg::req_class_type in_item,
   output logic                     in_pop,
   input  logic                     out_full,
   output logic                     out_push,
   output rle8d_pkg::rsp_item_type  out_item
);

   rle8d_pkg::ctl_state_type state_ff, state_in;
   rle8d_pkg::phase_type     phase_ff, phase_in;
   rle8d_pkg::req_class_type item_ff, item_in;

   logic [7:0]         held_ff, held_in;
   logic [7:0]         dx_ff, dx_in;
   logic [7:0]         lit_left_ff, lit_left_in;
   logic [7:0]         left_ff, left_in;
   logic               pad_ff, pad_in;
   logic               over_ff, over_in;
   logic               fresh_ff, fresh_in;
   logic               done_req_ff, done_req_in;
   logic               abs_ff, abs_in;
   logic [12:0]        cx_ff, cx_in;
   logic signed [12:0] cy_ff, cy_in;

   logic [11:0]        w_eff;
   logic [12:0]        w_ext;
   logic               cx_ge_w, cx_gt_w, cy_neg;
   logic [12:0]        cx_sub;
   logic signed [12:0] cy_dec;

   // encoded run segment
   logic [12:0]        x_eff, room, x_new;
   logic signed [12:0] y_eff;
   logic [7:0]         seg_len, left_new;
   logic               run_wrap_end;

   // literal byte
   logic               lit_emit, lit_done;
   logic [7:0]         lit_left_new;
   rle8d_pkg::phase_type lit_phase_new;

   // skip
   logic [13:0]        dx_sum;
   logic signed [13:0] dy_diff;

   logic               end_done;
   logic               fin, fin_done;

   assign w_eff   = (frame_width < rle8d_pkg::MIN_WIDTH) ? rle8d_pkg::MIN_WIDTH : frame_width;
   assign w_ext   = {1'b0, w_eff};
   assign cx_ge_w = (cx_ff >= w_ext);
   assign cx_gt_w = (cx_ff > w_ext);
   assign cx_sub  = cx_ff - w_ext;
   assign cy_neg  = cy_ff[12];
   assign cy_dec  = cy_neg ? cy_ff : cy_ff - 13'sd1;

   // one wrap at most can be due here: after the first segment x sits at the row end
   assign x_eff        = cx_ge_w ? cx_sub : cx_ff;
   assign y_eff        = cx_ge_w ? cy_dec : cy_ff;
   assign room         = w_ext - x_eff;
   assign seg_len      = ({5'd0, left_ff} < room) ? left_ff : room[7:0];
   assign x_new        = x_eff + {5'd0, seg_len};
   assign left_new     = left_ff - seg_len;
   // more pixels left but the next row would be below row 0
   assign run_wrap_end = (left_new != 8'd0) && (y_eff == 13'sd0);

   assign lit_emit      = !y_eff[12];
   assign lit_left_new  = lit_left_ff - 8'd1;
   assign lit_phase_new = (lit_left_new != 8'd0) ? rle8d_pkg::PH_LIT :
                          (pad_ff ? rle8d_pkg::PH_PAD : rle8d_pkg::PH_FIRST);
   assign lit_done      = item_ff.end_of_buffer ||
                          ((lit_phase_new == rle8d_pkg::PH_FIRST) && y_eff[12]);

   assign dx_sum  = {1'b0, cx_ff} + {6'd0, dx_ff};
   assign dy_diff = $signed({cy_ff[12], cy_ff}) - $signed({6'd0, item_ff.data_byte});

   assign end_done = done_req_ff || item_ff.end_of_buffer ||
                     ((phase_ff == rle8d_pkg::PH_FIRST) && cy_neg);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rle8d_pkg::ST_FETCH: begin
            if (in_valid && !over_ff) begin
               state_in = rle8d_pkg::ST_EXEC;
            end
         end
         rle8d_pkg::ST_EXEC: begin
            if (cy_neg) begin
               state_in = rle8d_pkg::ST_END;
            end else begin
               unique case (phase_ff)
                  rle8d_pkg::PH_SECOND: begin
                     priority if (held_ff != 8'd0) begin
                        state_in = rle8d_pkg::ST_WRAP;
                     end else if (item_ff.is_eol) begin
                        state_in = rle8d_pkg::ST_EOL;
                     end else if (item_ff.is_eoi || item_ff.is_delta) begin
                        state_in = rle8d_pkg::ST_END;
                     end else begin
                        state_in = rle8d_pkg::ST_WRAP;
                     end
                  end
                  rle8d_pkg::PH_LIT: begin
                     if (!((lit_emit || lit_done) && out_full)) begin
                        state_in = rle8d_pkg::ST_FETCH;
                     end
                  end
                  default: state_in = rle8d_pkg::ST_END;
               endcase
            end
         end
         rle8d_pkg::ST_WRAP: begin
            if (!cx_ge_w) begin
               state_in = abs_ff ? rle8d_pkg::ST_END : rle8d_pkg::ST_RUN;
            end
         end
         rle8d_pkg::ST_RUN: begin
            if (cy_neg) begin
               state_in = rle8d_pkg::ST_END;
            end else if (!out_full && ((left_new == 8'd0) || run_wrap_end)) begin
               state_in = rle8d_pkg::ST_FETCH;
            end
         end
         rle8d_pkg::ST_EOL: begin
            if (!cx_gt_w) begin
               state_in = rle8d_pkg::ST_END;
            end
         end
         rle8d_pkg::ST_END: begin
            if (!(end_done && out_full)) begin
               state_in = rle8d_pkg::ST_FETCH;
            end
         end
         default: state_in = rle8d_pkg::ST_FETCH;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in    = phase_ff;
      item_in     = item_ff;
      held_in     = held_ff;
      dx_in       = dx_ff;
      lit_left_in = lit_left_ff;
      left_in     = left_ff;
      pad_in      = pad_ff;
      over_in     = over_ff;
      fresh_in    = fresh_ff;
      done_req_in = done_req_ff;
      abs_in      = abs_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      in_pop      = 1'b0;
      out_push    = 1'b0;
      out_item    = '0;
      fin         = 1'b0;
      fin_done    = 1'b0;

      unique case (state_ff)
         rle8d_pkg::ST_FETCH: begin
            in_pop = in_valid;
            if (in_valid) begin
               item_in     = in_item;
               done_req_in = 1'b0;
               if (over_ff) begin
                  // drop bytes until the end of the buffer
                  if (in_item.end_of_buffer) begin
                     fresh_in    = 1'b1;
                     over_in     = 1'b0;
                     phase_in    = rle8d_pkg::PH_FIRST;
                     lit_left_in = 8'd0;
                     pad_in      = 1'b0;
                  end
               end else if (fresh_ff) begin
                  fresh_in = 1'b0;
                  cx_in    = '0;
                  cy_in    = $signed({1'b0, frame_height}) - 13'sd1;
                  phase_in = rle8d_pkg::PH_FIRST;
               end
            end
         end
         rle8d_pkg::ST_EXEC: begin
            if (cy_neg) begin
               done_req_in = 1'b1;
            end else begin
               unique case (phase_ff)
                  rle8d_pkg::PH_FIRST: begin
                     held_in  = item_ff.data_byte;
                     phase_in = rle8d_pkg::PH_SECOND;
                  end
                  rle8d_pkg::PH_SECOND: begin
                     phase_in = rle8d_pkg::PH_FIRST;
                     priority if (held_ff != 8'd0) begin
                        left_in = held_ff;
                        abs_in  = 1'b0;
                     end else if (item_ff.is_eol) begin
                        abs_in = 1'b0;
                     end else if (item_ff.is_eoi) begin
                        done_req_in = 1'b1;
                     end else if (item_ff.is_delta) begin
                        phase_in = rle8d_pkg::PH_DX;
                     end else begin
                        lit_left_in = item_ff.data_byte;
                        pad_in      = item_ff.data_byte[0];
                        phase_in    = rle8d_pkg::PH_LIT;
                        abs_in      = 1'b1;
                     end
                  end
                  rle8d_pkg::PH_DX: begin
                     dx_in    = item_ff.data_byte;
                     phase_in = rle8d_pkg::PH_DY;
                  end
                  rle8d_pkg::PH_DY: begin
                     cx_in    = dx_sum[13] ? '1 : dx_sum[12:0];
                     cy_in    = (dy_diff < -14'sd1) ? -13'sd1 : dy_diff[12:0];
                     phase_in = rle8d_pkg::PH_FIRST;
                  end
                  rle8d_pkg::PH_LIT: begin
                     if (!((lit_emit || lit_done) && out_full)) begin
                        cx_in       = x_eff + 13'd1;
                        cy_in       = y_eff;
                        lit_left_in = lit_left_new;
                        phase_in    = lit_phase_new;
                        out_push    = lit_emit || lit_done;
                        if (lit_emit) begin
                           out_item.pixel_x     = x_eff[11:0];
                           out_item.pixel_y     = y_eff[11:0];
                           out_item.run_length  = 8'd1;
                           out_item.pixel_value = item_ff.data_byte;
                        end
                        out_item.last_of_run = 1'b1;
                        out_item.frame_done  = lit_done;
                        fin      = 1'b1;
                        fin_done = lit_done;
                     end
                  end
                  default: begin
                     pad_in   = 1'b0;
                     phase_in = rle8d_pkg::PH_FIRST;
                  end
               endcase
            end
         end
         rle8d_pkg::ST_WRAP: begin
            if (cx_ge_w) begin
               cx_in = cx_sub;
               cy_in = cy_dec;
            end
         end
         rle8d_pkg::ST_RUN: begin
            if (!cy_neg && !out_full) begin
               out_push             = 1'b1;
               out_item.pixel_x     = x_eff[11:0];
               out_item.pixel_y     = y_eff[11:0];
               out_item.run_length  = seg_len;
               out_item.pixel_value = item_ff.data_byte;
               out_item.last_of_run = (left_new == 8'd0) || run_wrap_end;
               out_item.frame_done  = ((left_new == 8'd0) && item_ff.end_of_buffer) ||
                                      run_wrap_end;
               left_in = left_new;
               if (run_wrap_end) begin
                  cx_in    = '0;
                  cy_in    = -13'sd1;
                  fin      = 1'b1;
                  fin_done = 1'b1;
               end else begin
                  cx_in = x_new;
                  cy_in = y_eff;
                  if (left_new == 8'd0) begin
                     fin      = 1'b1;
                     fin_done = item_ff.end_of_buffer;
                  end
               end
            end
         end
         rle8d_pkg::ST_EOL: begin
            cy_in = cy_dec;
            cx_in = cx_gt_w ? cx_sub : '0;
         end
         rle8d_pkg::ST_END: begin
            // status-only result when the byte closes the frame without a segment
            if (end_done && !out_full) begin
               out_push             = 1'b1;
               out_item.last_of_run = 1'b1;
               out_item.frame_done  = 1'b1;
               fin                  = 1'b1;
               fin_done             = 1'b1;
            end
         end
         default: begin
            in_pop = 1'b0;
         end
      endcase

      if (fin && fin_done) begin
         if (item_ff.end_of_buffer) begin
            fresh_in    = 1'b1;
            over_in     = 1'b0;
            phase_in    = rle8d_pkg::PH_FIRST;
            lit_left_in = 8'd0;
            pad_in      = 1'b0;
         end else begin
            over_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rle8d_pkg::ST_FETCH;
         phase_ff    <= rle8d_pkg::PH_FIRST;
         held_ff     <= 8'd0;
         dx_ff       <= 8'd0;
         lit_left_ff <= 8'd0;
         pad_ff      <= 1'b0;
         over_ff     <= 1'b0;
         fresh_ff    <= 1'b1;
         done_req_ff <= 1'b0;
         abs_ff      <= 1'b0;
         cx_ff       <= '0;
         cy_ff       <= $signed({1'b0, rle8d_pkg::HEIGHT_RESET}) - 13'sd1;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         dx_ff       <= dx_in;
         lit_left_ff <= lit_left_in;
         pad_ff      <= pad_in;
         over_ff     <= over_in;
         fresh_ff    <= fresh_in;
         done_req_ff <= done_req_in;
         abs_ff      <= abs_in;
         cx_ff       <= cx_in;
         cy_ff       <= cy_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      left_ff <= left_in;
   end

endmodule

/* rtl/rle8_bitmap_decoder.sv */
`timescale 1ns / 1ps
// Path: each request passes the input queue, then the fetch and execute states of the decode
// sequencer, which writes a literal byte's result; a run segment goes on through the wrap and run
// states; a status-only result is written from the end state, after an end of line via end-of-line.
// Flow: bytes dropped after a frame ends are taken in the fetch state alone; every other byte is
// executed before the next is fetched, by the single decode sequencer, which also waits on a full
// result queue and takes each row wrap step in the wrap state.
// Reset (synchronous, active high) empties both queues, loads width 320 and height 240.
module rle8_bitmap_decoder #(
   parameter int IN_DEPTH  = 2,
   parameter int OUT_DEPTH = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  rle8d_pkg::req_item_type                 req_data,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output rle8d_pkg::rsp_item_type                 rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [rle8d_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [rle8d_pkg::COORD_BITS-1:0]        csr_wdata
);

   localparam int RW = $bits(rle8d_pkg::rsp_item_type);

   logic [rle8d_pkg::COORD_BITS-1:0] width_ff, width_in;
   logic [rle8d_pkg::COORD_BITS-1:0] height_ff, height_in;

   logic                     dec_valid, dec_pop;
   rle8d_pkg::req_class_type dec_item;
   logic                     out_full, out_push;
   rle8d_pkg::rsp_item_type  out_item;
   logic [RW-1:0]            out_dout;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rle8d_pkg::CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            rle8d_pkg::CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default:                     width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rle8d_pkg::WIDTH_RESET;
         height_ff <= rle8d_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   rle8d_front #(
      .DEPTH(IN_DEPTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .pop     (dec_pop),
      .valid   (dec_valid),
      .item    (dec_item)
   );

   rle8d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_width (width_ff),
      .frame_height(height_ff),
      .in_valid    (dec_valid),
      .in_item     (dec_item),
      .in_pop      (dec_pop),
      .out_full    (out_full),
      .out_push    (out_push),
      .out_item    (out_item)
   );

   rle8d_fifo #(
      .WIDTH(RW),
      .DEPTH(OUT_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push (out_push),
      .din  (out_item),
      .full (out_full),
      .pop  (rsp_pop),
      .dout (out_dout),
      .empty(rsp_empty)
   );

   assign rsp_data = rle8d_pkg::rsp_item_type'(out_dout);

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int X_LIMIT       = (1 << rle8d_pkg::X_BITS) - 1;
   localparam int SETTLE_CYCLES = 1200;   // covers an end of line that unwinds a saturated x

   logic                               clock;
   logic                               reset;
   logic                               req_push;
   logic                               req_full;
   rle8d_pkg::req_item_type            req_data;
   logic                               rsp_empty;
   logic                               rsp_pop;
   rle8d_pkg::rsp_item_type            rsp_data;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [rle8d_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [rle8d_pkg::COORD_BITS-1:0]   csr_wdata;

   rle8_bitmap_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // decoder state mirrored by the predictor
   logic [rle8d_pkg::COORD_BITS-1:0] width_reg  = rle8d_pkg::WIDTH_RESET;
   logic [rle8d_pkg::COORD_BITS-1:0] height_reg = rle8d_pkg::HEIGHT_RESET;
   rle8d_pkg::phase_type             cur_phase  = rle8d_pkg::PH_FIRST;
   logic [7:0]                       held_byte  = '0;
   int                               cur_x      = 0;
   int                               cur_y      = int'(rle8d_pkg::HEIGHT_RESET) - 1;
   logic [7:0]                       lit_left   = '0;
   bit                               pad_flag   = 0;
   logic [7:0]                       dx_held    = '0;
   bit                               frame_over = 0;
   bit                               frame_fresh = 1;

   rle8d_pkg::rsp_item_type expected_segs[$];
   rle8d_pkg::req_item_type frame_bytes[$];
   int           error_count    = 0;
   int           items_sent     = 0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic rle8d_pkg::rsp_item_type make_seg(int x, int y, int len, int val);
      rle8d_pkg::rsp_item_type s;
      s = '0;
      s.pixel_x     = x[rle8d_pkg::COORD_BITS-1:0];
      s.pixel_y     = y[rle8d_pkg::COORD_BITS-1:0];
      s.run_length  = len[7:0];
      s.pixel_value = val[7:0];
      return s;
   endfunction

   function automatic void move_down(int k);
      cur_y -= k;
      if (cur_y < -1)
         cur_y = -1;
   endfunction

   function automatic void wrap_row(int w);
      while (cur_x >= w) begin
         cur_x -= w;
         move_down(1);
      end
   endfunction

   function automatic void rearm_frame();
      frame_fresh = 1;
      frame_over  = 0;
      cur_phase   = rle8d_pkg::PH_FIRST;
      lit_left    = '0;
      pad_flag    = 0;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic eob);
      rle8d_pkg::rsp_item_type segs[$];
      int w;
      int left;
      int room;
      int len;
      bit done;
      done = 0;
      w = (width_reg < rle8d_pkg::MIN_WIDTH) ? int'(rle8d_pkg::MIN_WIDTH) : int'(width_reg);
      if (frame_over) begin
         if (eob)
            rearm_frame();
         return;
      end
      if (frame_fresh) begin
         frame_fresh = 0;
         cur_x = 0;
         cur_y = int'(height_reg) - 1;
         cur_phase = rle8d_pkg::PH_FIRST;
      end
      if (cur_y < 0) begin
         done = 1;
      end else begin
         case (cur_phase)
            rle8d_pkg::PH_FIRST: begin
               held_byte = b;
               cur_phase = rle8d_pkg::PH_SECOND;
            end
            rle8d_pkg::PH_SECOND: begin
               cur_phase = rle8d_pkg::PH_FIRST;
               if (held_byte != 8'd0) begin
                  left = int'(held_byte);
                  wrap_row(w);
                  while (left > 0 && cur_y >= 0) begin
                     if (cur_x >= w) begin
                        cur_x -= w;
                        move_down(1);
                        if (cur_y < 0)
                           break;
                     end
                     room = w - cur_x;
                     len = (left < room) ? left : room;
                     segs.push_back(make_seg(cur_x, cur_y, len, int'(b)));
                     cur_x += len;
                     left -= len;
                  end
               end else if (b == rle8d_pkg::ESC_EOL) begin
                  while (cur_x > w) begin
                     cur_x -= w;
                     move_down(1);
                  end
                  cur_x = 0;
                  move_down(1);
               end else if (b == rle8d_pkg::ESC_EOI) begin
                  done = 1;
               end else if (b == rle8d_pkg::ESC_DELTA) begin
                  cur_phase = rle8d_pkg::PH_DX;
               end else begin
                  wrap_row(w);
                  lit_left  = b;
                  pad_flag  = b[0];
                  cur_phase = rle8d_pkg::PH_LIT;
               end
            end
            rle8d_pkg::PH_DX: begin
               dx_held   = b;
               cur_phase = rle8d_pkg::PH_DY;
            end
            rle8d_pkg::PH_DY: begin
               cur_x += int'(dx_held);
               if (cur_x > X_LIMIT)
                  cur_x = X_LIMIT;
               move_down(int'(b));
               cur_phase = rle8d_pkg::PH_FIRST;
            end
            rle8d_pkg::PH_LIT: begin
               if (cur_x >= w) begin
                  cur_x -= w;
                  move_down(1);
               end
               if (cur_y >= 0)
                  segs.push_back(make_seg(cur_x, cur_y, 1, int'(b)));
               cur_x++;
               lit_left = lit_left - 8'd1;
               if (lit_left == 8'd0)
                  cur_phase = pad_flag ? rle8d_pkg::PH_PAD : rle8d_pkg::PH_FIRST;
            end
            default: begin
               pad_flag  = 0;
               cur_phase = rle8d_pkg::PH_FIRST;
            end
         endcase
         if (cur_phase == rle8d_pkg::PH_FIRST && cur_y < 0)
            done = 1;
      end

      if (eob)
         done = 1;
      if (done) begin
         if (segs.size() == 0)
            segs.push_back(make_seg(0, 0, 0, 0));
         segs[segs.size()-1].frame_done = 1'b1;
         if (eob)
            rearm_frame();
         else
            frame_over = 1;
      end
      if (segs.size() > 0)
         segs[segs.size()-1].last_of_run = 1'b1;
      for (int i = 0; i < segs.size(); i++)
         expected_segs.push_back(segs[i]);
   endfunction

   // ---------------------------------------------------------------- result side

   function automatic void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
         $error("%s: expected %0d, got %0d", name, exp, act);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      rle8d_pkg::rsp_item_type seg;
      if (reset)
         rsp_pop <= 1'b0;
      else
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_segs.size() == 0) begin
            $error("segment with none expected: %p", rsp_data);
            error_count++;
         end else begin
            seg = expected_segs.pop_front();
            check_field("pixel_x", seg.pixel_x, rsp_data.pixel_x);
            check_field("pixel_y", seg.pixel_y, rsp_data.pixel_y);
            check_field("run_length", seg.run_length, rsp_data.run_length);
            check_field("pixel_value", seg.pixel_value, rsp_data.pixel_value);
            check_field("last_of_run", seg.last_of_run, rsp_data.last_of_run);
            check_field("frame_done", seg.frame_done, rsp_data.frame_done);
         end
      end
   end

   // ---------------------------------------------------------------- request side

   task automatic send_item(input rle8d_pkg::req_item_type item);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_data <= item;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      items_sent++;
      decode_byte(item.data_byte, item.end_of_buffer);
   endtask

   // the last byte of the frame carries end_of_buffer
   task automatic send_frame();
      rle8d_pkg::req_item_type item;
      for (int i = 0; i < frame_bytes.size(); i++) begin
         item = frame_bytes[i];
         item.end_of_buffer = (i == frame_bytes.size() - 1);
         send_item(item);
      end
      frame_bytes.delete();
   endtask

   function automatic void put_byte(input logic [7:0] b);
      rle8d_pkg::req_item_type item;
      item.data_byte     = b;
      item.end_of_buffer = 1'b0;
      frame_bytes.push_back(item);
   endfunction

   function automatic void put_run(input int count, input logic [7:0] value);
      put_byte(count[7:0]);
      put_byte(value);
   endfunction

   function automatic void put_escape(input logic [7:0] code);
      put_byte(8'h00);
      put_byte(code);
   endfunction

   function automatic void put_skip(input int dx, input int dy);
      put_escape(rle8d_pkg::ESC_DELTA);
      put_byte(dx[7:0]);
      put_byte(dy[7:0]);
   endfunction

   function automatic void put_literal(input int count);
      put_escape(count[7:0]);
      repeat (count) put_byte(8'($urandom_range(255)));
      if (count % 2 != 0)
         put_byte(8'($urandom_range(255)));
   endfunction

   // wait until every request has played out, including ones that give no segment
   task automatic settle();
      req_push <= 1'b0;
      while (expected_segs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rle8d_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [rle8d_pkg::COORD_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == rle8d_pkg::CSR_FRAME_WIDTH)
         width_reg = value;
      else
         height_reg = value;
   endtask

   task automatic configure(input int w, input int h);
      settle();
      write_reg(rle8d_pkg::CSR_FRAME_WIDTH, w[rle8d_pkg::COORD_BITS-1:0]);
      write_reg(rle8d_pkg::CSR_FRAME_HEIGHT, h[rle8d_pkg::COORD_BITS-1:0]);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // reset geometry, every code once, bytes after end of image ignored
   task automatic test_reset_geometry();
      put_run(5, 8'hAA);
      put_escape(rle8d_pkg::ESC_EOL);
      put_literal(3);
      put_skip(10, 1);
      put_run(255, 8'hFF);
      put_escape(rle8d_pkg::ESC_EOI);
      put_byte(8'h12);
      put_byte(8'h34);
      send_frame();
   endtask

   // minimum width: a 255 run from x=7 splits into the most segments
   task automatic test_narrow_rows();
      configure(8, 40);
      put_run(7, 8'h00);
      put_run(255, 8'h55);
      put_literal(4);
      put_run(1, 8'h80);
      put_byte(8'h05);     // data ends inside a code
      send_frame();
   endtask

   task automatic test_size_limits();
      // width below minimum, single row: run runs out of rows
      configure(5, 1);
      put_run(20, 8'h33);
      put_byte(8'h99);
      put_byte(8'h01);
      send_frame();
      // zero height ends the frame on its first byte
      configure(4095, 0);
      put_byte(8'h7F);
      put_byte(8'h00);
      send_frame();
      configure(4095, 4095);
      put_skip(255, 255);
      put_run(255, 8'hC3);
      put_escape(rle8d_pkg::ESC_EOL);
      put_literal(5);
      put_escape(rle8d_pkg::ESC_EOI);
      send_frame();
      // large dy pins y at -1
      configure(8, 3);
      put_run(3, 8'h11);
      put_skip(0, 255);
      put_byte(8'hEE);
      send_frame();
   endtask

   task automatic test_skip_saturation();
      configure(8, 4095);
      repeat (33) put_skip(255, 0);
      put_escape(rle8d_pkg::ESC_EOL);
      put_run(3, 8'h5A);
      send_frame();
   endtask

   task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                     input int n_items);
      int target;
      int pick;
      int w;
      int h;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      target = items_sent + n_items;
      while (items_sent < target) begin
         if ($urandom_range(99) < 35) begin
            case ($urandom_range(5))
               0:       w = 8;
               1:       w = 4095;
               2:       w = $urandom_range(0, 7);
               default: w = $urandom_range(8, 64);
            endcase
            case ($urandom_range(7))
               0:       h = 0;
               1:       h = 4095;
               2:       h = 1;
               default: h = $urandom_range(2, 24);
            endcase
            configure(w, h);
         end
         repeat ($urandom_range(2, 6)) begin
            pick = $urandom_range(99);
            if (pick < 40)
               put_run(($urandom_range(1) != 0) ? $urandom_range(1, 16) : $urandom_range(1, 255),
                       8'($urandom_range(255)));
            else if (pick < 60)
               put_literal($urandom_range(3, 12));
            else if (pick < 72)
               put_escape(rle8d_pkg::ESC_EOL);
            else if (pick < 82)
               put_skip($urandom_range(255),
                        ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(3));
            else if (pick < 86)
               put_escape(rle8d_pkg::ESC_EOI);
            else
               put_byte(8'($urandom_range(255)));   // misaligns the parse
         end
         if ($urandom_range(4) == 0)
            put_byte(8'($urandom_range(1, 255)));   // cut off mid-code
         send_frame();
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_push  <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_geometry();
      test_narrow_rows();
      test_size_limits();
      test_skip_saturation();
      test_random_frames(0, 0, 15);
      test_random_frames(63, 0, 15);
      test_random_frames(0, 63, 15);
      test_random_frames(13, 13, 15);

      settle();
      if (error_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/rle8d_pkg.sv
rtl/rle8d_fifo.sv
rtl/rle8d_front.sv
rtl/rle8d_back.sv
rtl/rle8_bitmap_decoder.sv
test/testbench.sv
